>>> hw/rtl/pps_pkg.sv
// Package for the particle pool block: sizes, pool entry layout, codes and state types.
// Used by every module of the block; depends on nothing.
package pps_pkg;

  localparam int POOL_SIZE = 64;
  localparam int SLOT_W    = $clog2(POOL_SIZE);
  localparam int IN_W      = 120;
  localparam int OUT_W     = 112;
  localparam int CFG_W     = 48;

  typedef struct packed {
    logic [2:0][23:0] pos;
    logic [2:0][15:0] vel;
    logic [15:0]      total;
    logic [16:0]      left;
  } entry_t;

  typedef enum logic [2:0] {
    CFG_SPAWN_INTERVAL,
    CFG_VELOCITY_MIN,
    CFG_VELOCITY_MAX,
    CFG_LIFE_MIN,
    CFG_LIFE_MAX,
    CFG_START_COLOR,
    CFG_END_COLOR,
    CFG_EMITTER_ENABLE
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SP_MUL,
    ST_SP_ACC,
    ST_SP_WR,
    ST_RD,
    ST_CHK,
    ST_MV_MUL,
    ST_MV_ACC,
    ST_WB,
    ST_DIV,
    ST_COL,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic        start;
    logic [15:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic [5:0]       slot;
    logic [2:0][23:0] pos;
    logic [31:0]      color;
  } item_t;

endpackage

>>> hw/rtl/pps_ram.sv
// Pool memory: one write port and one read port with registered read data.
// Depends on pps_pkg for the entry layout and pool size.
module pps_ram (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [pps_pkg::SLOT_W-1:0]    waddr_i,
  input  pps_pkg::entry_t               wdata_i,
  input  logic [pps_pkg::SLOT_W-1:0]    raddr_i,
  output pps_pkg::entry_t               rdata_o
);
  import pps_pkg::*;

  entry_t mem_q [POOL_SIZE];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/pps_mul.sv
// Shared multiplier: signed 17 bit by unsigned 16 bit with a registered product.
// Depends on pps_pkg only by convention of the block.
module pps_mul (
  input  logic               clk_i,
  input  logic signed [16:0] a_i,
  input  logic [15:0]        b_i,
  output logic signed [32:0] p_o
);
  import pps_pkg::*;

  logic signed [33:0] prod;
  logic signed [32:0] p_q;

  assign prod = a_i * $signed({1'b0, b_i});

  always_ff @(posedge clk_i) begin
    p_q <= prod[32:0];
  end

  assign p_o = p_q;

endmodule

>>> hw/rtl/pps_div.sv
// Restoring divider for the age fraction, one quotient bit per cycle.
// Depends on pps_pkg for the request and response structs.
module pps_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pps_pkg::div_req_t req_i,
  output pps_pkg::div_rsp_t rsp_o
);
  import pps_pkg::*;

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [15:0] rem_q, rem_d;
  logic [15:0] quot_q, quot_d;
  logic [15:0] dvs_q, dvs_d;
  logic [16:0] shifted;
  logic [16:0] diff;

  assign shifted = {rem_q, 1'b0};
  assign diff    = shifted - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 5'd16;
      rem_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      quot_d = '0;
    end else if (busy_q) begin
      if (!diff[16]) begin
        rem_d  = diff[15:0];
        quot_d = {quot_q[14:0], 1'b1};
      end else begin
        rem_d  = shifted[15:0];
        quot_d = {quot_q[14:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    dvs_q  <= dvs_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

>>> hw/rtl/particle_pool_step.sv
// Particle pool emitter: a tick spawns, ages and moves particles and streams them out.
// A tick with the emitter disabled is taken and does no work. An enabled tick may spawn one
// particle, then walks the pool memory one slot at a time; a live slot is moved and, unless
// its age fraction is trivial, waits on the serial age divider, and output stalls can hold it.
// Reset sets the registers to their defaults and clears the pool valid bits; no clearing pass.
module particle_pool_step (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // time_step, emitter_x, emitter_y, emitter_z, rand_velocity, rand_life
  input  logic [pps_pkg::IN_W-1:0]   s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // slot, pos_x, pos_y, pos_z, color, zero fill
  output logic [pps_pkg::OUT_W-1:0]  m_axis_tdata,
  output logic                       m_axis_tlast,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [2:0]                 cfg_index_i,
  input  logic [pps_pkg::CFG_W-1:0]  cfg_data_i
);
  import pps_pkg::*;

  logic [15:0] interval_q, lmin_q, lmax_q;
  logic [47:0] vmin_q, vmax_q;
  logic [31:0] scol_q, ecol_q;
  logic        en_q;

  state_e             state_q, state_d;
  logic [16:0]        timer_q, timer_d;
  logic [SLOT_W-1:0]  sslot_q, sslot_d;
  logic [POOL_SIZE-1:0] active_q, active_d;
  logic [SLOT_W-1:0]  idx_q, idx_d;
  logic [1:0]         lane_q, lane_d;
  logic               pend_valid_q, pend_valid_d;
  logic               out_valid_q, out_valid_d;
  logic               out_last_q, out_last_d;

  logic [15:0]        dt_q, dt_d, rv_q, rv_d, rl_q, rl_d;
  entry_t             ent_q, ent_d;
  logic [16:0]        alpha_q, alpha_d;
  item_t              pend_q, pend_d, out_q, out_d;

  entry_t             rdata;
  logic               mem_we;
  logic signed [16:0] mul_a;
  logic [15:0]        mul_b;
  logic signed [32:0] mul_p;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  logic [17:0]        tsum;
  logic               out_free;
  logic               last_slot;
  logic signed [16:0] lo17, hi17, sum17;
  logic signed [16:0] left_s;
  logic [31:0]        color_c;
  item_t              new_item;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= 16'd4096;
      vmin_q     <= '0;
      vmax_q     <= '0;
      lmin_q     <= 16'd4096;
      lmax_q     <= 16'd4096;
      scol_q     <= 32'hFFFF_FFFF;
      ecol_q     <= '0;
      en_q       <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_SPAWN_INTERVAL: interval_q <= cfg_data_i[15:0];
        CFG_VELOCITY_MIN:   vmin_q     <= cfg_data_i;
        CFG_VELOCITY_MAX:   vmax_q     <= cfg_data_i;
        CFG_LIFE_MIN:       lmin_q     <= cfg_data_i[15:0];
        CFG_LIFE_MAX:       lmax_q     <= cfg_data_i[15:0];
        CFG_START_COLOR:    scol_q     <= cfg_data_i[31:0];
        CFG_END_COLOR:      ecol_q     <= cfg_data_i[31:0];
        CFG_EMITTER_ENABLE: en_q       <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  pps_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (idx_q),
    .wdata_i (ent_q),
    .raddr_i (idx_q),
    .rdata_o (rdata)
  );

  pps_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  pps_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      logic signed [8:0]  d9;
      logic signed [26:0] cp;
      d9 = $signed({1'b0, ecol_q[8*b +: 8]}) - $signed({1'b0, scol_q[8*b +: 8]});
      cp = d9 * $signed({1'b0, alpha_q});
      color_c[8*b +: 8] = scol_q[8*b +: 8] + cp[23:16];
    end
  end

  assign new_item.slot  = 6'(idx_q);
  assign new_item.pos   = ent_q.pos;
  assign new_item.color = color_c;

  assign out_free  = !out_valid_q || m_axis_tready;
  assign last_slot = (idx_q == '0);
  assign tsum      = {1'b0, timer_q} + {2'b0, s_axis_tdata[15:0]};
  assign mem_we    = (state_q == ST_SP_WR) || (state_q == ST_WB);
  assign s_axis_tready = (state_q == ST_IDLE);
  assign left_s    = $signed(ent_q.left);

  always_comb begin
    lo17 = '0;
    hi17 = '0;
    if (lane_q == 2'd3) begin
      lo17 = $signed({1'b0, lmin_q});
      hi17 = $signed({1'b0, lmax_q});
    end else begin
      lo17 = $signed({vmin_q[16*lane_q + 15], vmin_q[16*lane_q +: 16]});
      hi17 = $signed({vmax_q[16*lane_q + 15], vmax_q[16*lane_q +: 16]});
    end
    sum17 = lo17 + mul_p[32:16];
    if (state_q == ST_MV_MUL) begin
      mul_a = $signed({ent_q.vel[lane_q[1:0]][15], ent_q.vel[lane_q[1:0]]});
      mul_b = dt_q;
    end else begin
      mul_a = hi17 - lo17;
      mul_b = (lane_q == 2'd3) ? rl_q : rv_q;
    end
  end

  always_comb begin
    state_d      = state_q;
    timer_d      = timer_q;
    sslot_d      = sslot_q;
    active_d     = active_q;
    idx_d        = idx_q;
    lane_d       = lane_q;
    pend_valid_d = pend_valid_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_last_d   = out_last_q;
    dt_d         = dt_q;
    rv_d         = rv_q;
    rl_d         = rl_q;
    ent_d        = ent_q;
    alpha_d      = alpha_q;
    pend_d       = pend_q;
    out_d        = out_q;
    div_req      = '0;

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid && en_q) begin
          dt_d = s_axis_tdata[15:0];
          rv_d = s_axis_tdata[103:88];
          rl_d = s_axis_tdata[119:104];
          idx_d = SLOT_W'(POOL_SIZE - 1);
          state_d = ST_RD;
          if (tsum >= {2'b0, interval_q}) begin
            timer_d = '0;
            sslot_d = (sslot_q == SLOT_W'(POOL_SIZE - 1)) ? '0 : sslot_q + 1'b1;
            if (!active_q[sslot_q]) begin
              idx_d     = sslot_q;
              ent_d.pos = s_axis_tdata[87:16];
              lane_d    = '0;
              state_d   = ST_SP_MUL;
            end
          end else begin
            timer_d = tsum[16:0];
          end
        end
      end
      ST_SP_MUL: state_d = ST_SP_ACC;
      ST_SP_ACC: begin
        if (lane_q == 2'd3) begin
          ent_d.total = sum17[15:0];
          ent_d.left  = {1'b0, sum17[15:0]};
          state_d     = ST_SP_WR;
        end else begin
          ent_d.vel[lane_q] = sum17[15:0];
          lane_d  = lane_q + 2'd1;
          state_d = ST_SP_MUL;
        end
      end
      ST_SP_WR: begin
        active_d[idx_q] = 1'b1;
        idx_d   = SLOT_W'(POOL_SIZE - 1);
        state_d = ST_RD;
      end
      ST_RD: state_d = ST_CHK;
      ST_CHK: begin
        if (!active_q[idx_q] || $signed(rdata.left) <= 17'sd0) begin
          active_d[idx_q] = 1'b0;
          if (last_slot) begin
            state_d = ST_FLUSH;
          end else begin
            idx_d   = idx_q - 1'b1;
            state_d = ST_RD;
          end
        end else begin
          ent_d      = rdata;
          ent_d.left = rdata.left - {1'b0, dt_q};
          lane_d     = '0;
          state_d    = ST_MV_MUL;
        end
      end
      ST_MV_MUL: state_d = ST_MV_ACC;
      ST_MV_ACC: begin
        ent_d.pos[lane_q] = ent_q.pos[lane_q] + {{3{mul_p[32]}}, mul_p[32:12]};
        if (lane_q == 2'd2) begin
          state_d = ST_WB;
        end else begin
          lane_d  = lane_q + 2'd1;
          state_d = ST_MV_MUL;
        end
      end
      ST_WB: begin
        if (left_s <= 17'sd0 || ent_q.total == '0
            || left_s > $signed({1'b0, ent_q.total})) begin
          alpha_d = 17'h10000;
          state_d = ST_COL;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = ent_q.total - ent_q.left[15:0];
          div_req.divisor  = ent_q.total;
          state_d          = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          alpha_d = {1'b0, div_rsp.quot};
          state_d = ST_COL;
        end
      end
      ST_COL: begin
        if (!pend_valid_q || out_free) begin
          if (pend_valid_q) begin
            out_d       = pend_q;
            out_last_d  = 1'b0;
            out_valid_d = 1'b1;
          end
          pend_d       = new_item;
          pend_valid_d = 1'b1;
          if (last_slot) begin
            state_d = ST_FLUSH;
          end else begin
            idx_d   = idx_q - 1'b1;
            state_d = ST_RD;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_valid_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_d        = pend_q;
          out_last_d   = 1'b1;
          out_valid_d  = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      timer_q      <= 17'd4096;
      sslot_q      <= '0;
      active_q     <= '0;
      idx_q        <= '0;
      lane_q       <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      out_last_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      timer_q      <= timer_d;
      sslot_q      <= sslot_d;
      active_q     <= active_d;
      idx_q        <= idx_d;
      lane_q       <= lane_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      out_last_q   <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dt_q    <= dt_d;
    rv_q    <= rv_d;
    rl_q    <= rl_d;
    ent_q   <= ent_d;
    alpha_q <= alpha_d;
    pend_q  <= pend_d;
    out_q   <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {2'b0, out_q.color, out_q.pos, out_q.slot};

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !mem_we)
    else $error("pool memory written while idle");

  a_disabled_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && !en_q) |=> (state_q == ST_IDLE))
    else $error("disabled tick started work");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_DIV))
    else $error("divider finished outside its wait state");

  a_alpha_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COL) |-> (alpha_q <= 17'h10000))
    else $error("age fraction above one");

endmodule

>>> tb/sv/tb_particle_pool_step.sv
// Self-checking testbench for particle_pool_step: drives ticks and register writes, and
// checks every emitted particle against a predictor of the pool kept inside this file.
// Depends on pps_pkg and the particle_pool_step RTL only.
`timescale 1ns / 1ps

module tb_particle_pool_step;
  import pps_pkg::*;

  localparam int SETTLE_CYC = 2000;
  localparam int WATCHDOG   = 20000;
  localparam int HOLD_CYC   = 3000;

  typedef struct {
    logic [15:0] dt;
    logic [23:0] ex, ey, ez;
    logic [15:0] rv, rl;
  } tick_t;

  typedef struct {
    logic [5:0]  slot;
    logic [23:0] px, py, pz;
    logic [31:0] color;
    bit          last;
  } particle_t;

  typedef struct {
    bit          is_cfg;
    cfg_reg_e    idx;
    logic [47:0] val;
    tick_t       tick;
    int          known_n;
    logic [31:0] known_color;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic m_axis_tlast;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;

  particle_pool_step dut (.*);

  always #5 clk_i = ~clk_i;

  // Predictor state.
  logic [15:0] spawn_gap, life_lo, life_hi;
  logic [47:0] vel_lo, vel_hi;
  logic [31:0] color_birth, color_death;
  bit          running;
  bit          alive [POOL_SIZE];
  logic [23:0] ppos [POOL_SIZE][3];
  int          pvel [POOL_SIZE][3];
  int          plife_total [POOL_SIZE];
  int          plife_left [POOL_SIZE];
  int          spawn_clock;
  int          next_slot;

  particle_t pending_particles[$];
  row_t      rows[$];

  int tx_idle_pct = 0, rx_idle_pct = 0;
  bit hold_req = 0, hold_rx = 0;
  int mismatches = 0, ticks_sent = 0, particles_seen = 0, cfg_writes = 0, busiest_tick = 0;
  int quiet_cycles = 0;

  function automatic longint lerp16(longint a, longint b, longint frac);
    return a + (((b - a) * frac) >>> 16);
  endfunction

  function automatic void add_row(input row_t r);
    rows = {rows, r};
  endfunction

  task automatic step_pool(input tick_t t);
    int tsum, n;
    longint d, alpha;
    logic [31:0] col;
    particle_t p;
    if (!running) return;
    tsum = spawn_clock + t.dt;
    if (tsum >= spawn_gap) begin
      tsum = 0;
      if (!alive[next_slot]) begin
        alive[next_slot] = 1;
        ppos[next_slot][0] = t.ex;
        ppos[next_slot][1] = t.ey;
        ppos[next_slot][2] = t.ez;
        for (int c = 0; c < 3; c++)
          pvel[next_slot][c] = int'(lerp16(longint'($signed(vel_lo[16*c +: 16])),
                                           longint'($signed(vel_hi[16*c +: 16])), t.rv));
        plife_total[next_slot] = int'(lerp16(life_lo, life_hi, t.rl)) & 16'hFFFF;
        plife_left[next_slot] = plife_total[next_slot];
      end
      next_slot = (next_slot + 1) % POOL_SIZE;
    end
    spawn_clock = tsum & 17'h1FFFF;
    for (int i = 0; i < POOL_SIZE; i++) begin
      if (!alive[i]) continue;
      if (plife_left[i] <= 0) begin
        alive[i] = 0;
        continue;
      end
      plife_left[i] -= t.dt;
      for (int c = 0; c < 3; c++) begin
        d = (longint'(pvel[i][c]) * t.dt) >>> 12;
        ppos[i][c] = ppos[i][c] + d[23:0];
      end
    end
    n = 0;
    for (int i = POOL_SIZE - 1; i >= 0; i--) begin
      if (!alive[i]) continue;
      if (plife_left[i] <= 0 || plife_total[i] == 0 || plife_left[i] >= plife_total[i] + 1)
        alpha = 65536;
      else
        alpha = (longint'(plife_total[i] - plife_left[i]) << 16) / plife_total[i];
      for (int b = 0; b < 4; b++)
        col[8*b +: 8] = 8'(lerp16(color_birth[8*b +: 8], color_death[8*b +: 8], alpha));
      p.slot = 6'(i);
      p.px = ppos[i][0];
      p.py = ppos[i][1];
      p.pz = ppos[i][2];
      p.color = col;
      p.last = 0;
      pending_particles.insert(pending_particles.size(), p);
      n++;
    end
    if (n > 0) pending_particles[$].last = 1;
    if (n > busiest_tick) busiest_tick = n;
  endtask

  task automatic reset_pool();
    spawn_gap = 16'd4096;
    vel_lo = '0;
    vel_hi = '0;
    life_lo = 16'd4096;
    life_hi = 16'd4096;
    color_birth = 32'hFFFF_FFFF;
    color_death = '0;
    running = 1;
    for (int i = 0; i < POOL_SIZE; i++) alive[i] = 0;
    spawn_clock = 4096;
    next_slot = 0;
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [47:0] val);
    s_axis_tvalid <= 1'b0;
    wait (pending_particles.size() == 0);
    repeat (SETTLE_CYC) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cfg_writes++;
    case (idx)
      CFG_SPAWN_INTERVAL: spawn_gap = val[15:0];
      CFG_VELOCITY_MIN:   vel_lo = val;
      CFG_VELOCITY_MAX:   vel_hi = val;
      CFG_LIFE_MIN:       life_lo = val[15:0];
      CFG_LIFE_MAX:       life_hi = val[15:0];
      CFG_START_COLOR:    color_birth = val[31:0];
      CFG_END_COLOR:      color_death = val[31:0];
      CFG_EMITTER_ENABLE: running = val[0];
      default: ;
    endcase
  endtask

  task automatic send_tick(input tick_t t, input int known_n, input logic [31:0] known_color);
    int base_cnt;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {t.rl, t.rv, t.ez, t.ey, t.ex, t.dt};
    do @(posedge clk_i); while (!s_axis_tready);
    ticks_sent++;
    base_cnt = pending_particles.size();
    step_pool(t);
    if (known_n >= 0) begin
      if (pending_particles.size() - base_cnt != known_n) begin
        mismatches++;
        $display("directed tick %0d: predicted %0d particles, table says %0d",
                 ticks_sent, pending_particles.size() - base_cnt, known_n);
      end
      for (int k = base_cnt; k < pending_particles.size(); k++)
        pending_particles[k].color = known_color;
    end
  endtask

  function automatic tick_t rand_tick();
    tick_t t;
    t.dt = ($urandom_range(99) < 70) ? 16'($urandom_range(0, 16'h0800)) : 16'($urandom);
    t.ex = 24'($urandom);
    t.ey = 24'($urandom);
    t.ez = 24'($urandom);
    t.rv = 16'($urandom);
    t.rl = 16'($urandom);
    return t;
  endfunction

  function automatic row_t tick_row(input logic [15:0] dt, input logic [23:0] ex, ey, ez,
                                    input logic [15:0] rv, rl,
                                    input int known_n = -1, input logic [31:0] kc = '0);
    row_t r;
    r.is_cfg = 0;
    r.idx = CFG_SPAWN_INTERVAL;
    r.val = '0;
    r.tick = '{dt, ex, ey, ez, rv, rl};
    r.known_n = known_n;
    r.known_color = kc;
    return r;
  endfunction

  function automatic row_t cfg_row(input cfg_reg_e idx, input logic [47:0] val);
    row_t r;
    r = tick_row('0, '0, '0, '0, '0, '0);
    r.is_cfg = 1;
    r.idx = idx;
    r.val = val;
    return r;
  endfunction

  // Receiver: random stalls plus one long hold requested by the stimulus.
  always @(posedge clk_i) begin
    m_axis_tready <= !hold_rx && ($urandom_range(99) >= rx_idle_pct);
  end

  initial begin
    wait (hold_req);
    hold_rx = 1;
    repeat (HOLD_CYC) @(posedge clk_i);
    hold_rx = 0;
  end

  always @(posedge clk_i) begin
    particle_t e;
    logic [111:0] d;
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
          || (cfg_valid_i && cfg_ready_o))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG) begin
        $display("watchdog: no handshake for %0d cycles", WATCHDOG);
        $display("tb_particle_pool_step: errors");
        $finish;
      end else if (m_axis_tvalid && m_axis_tready) begin
        d = m_axis_tdata;
        particles_seen++;
        if (pending_particles.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected particle item: slot %0d", d[5:0]);
        end else begin
          e = pending_particles.pop_front();
          if (d[5:0] !== e.slot || d[29:6] !== e.px || d[53:30] !== e.py ||
              d[77:54] !== e.pz || d[109:78] !== e.color || m_axis_tlast !== e.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: exp slot %0d pos %h %h %h col %h last %b",
                       e.slot, e.px, e.py, e.pz, e.color, e.last);
              $display("          got slot %0d pos %h %h %h col %h last %b",
                       d[5:0], d[29:6], d[53:30], d[77:54], d[109:78], m_axis_tlast);
            end
          end
        end
      end
    end
  end

  initial begin
    reset_pool();
    // After reset: a zero step still spawns, since the timer starts at the interval.
    add_row(tick_row(16'h0000, 24'h7FFFFF, 24'h800000, 24'h000001, 16'h0, 16'h0,
                     1, 32'hFFFF_FFFF));
    add_row(tick_row(16'h1000, 24'h000000, 24'hFFFFFF, 24'h123456, 16'hFFFF, 16'hFFFF,
                     2, 32'h0000_0000));
    add_row(tick_row(16'h0000, 24'h0, 24'h0, 24'h0, 16'h0, 16'h0, 0, '0));
    add_row(cfg_row(CFG_SPAWN_INTERVAL, 48'h0));
    add_row(cfg_row(CFG_VELOCITY_MIN, 48'h8000_8000_8000));
    add_row(cfg_row(CFG_VELOCITY_MAX, 48'h7FFF_7FFF_7FFF));
    add_row(cfg_row(CFG_LIFE_MIN, 48'hFFFF));
    add_row(cfg_row(CFG_LIFE_MAX, 48'h0001));
    add_row(cfg_row(CFG_START_COLOR, 48'h00FF_00FF));
    add_row(cfg_row(CFG_END_COLOR, 48'hFF00_FF00));
    add_row(tick_row(16'hFFFF, 24'h800000, 24'h7FFFFF, 24'h800000, 16'hFFFF, 16'hFFFF));
    add_row(tick_row(16'h0001, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'h0000, 16'h0000));
    add_row(tick_row(16'h0100, 24'h000100, 24'hFFFF00, 24'h0, 16'h8000, 16'h0000));
    add_row(tick_row(16'h0000, 24'h0, 24'h0, 24'h0, 16'h0000, 16'h0000));
    add_row(tick_row(16'h0800, 24'hABCDEF, 24'h0, 24'h0, 16'h4000, 16'h0001));
    add_row(cfg_row(CFG_EMITTER_ENABLE, 48'h0));
    add_row(tick_row(16'h0800, 24'h1, 24'h2, 24'h3, 16'h1234, 16'h4321, 0, '0));
    add_row(cfg_row(CFG_EMITTER_ENABLE, 48'h1));
    add_row(cfg_row(CFG_SPAWN_INTERVAL, 48'hFFFF));
    add_row(tick_row(16'hFFFF, 24'h5, 24'h6, 24'h7, 16'hFFFF, 16'h0000));
    add_row(tick_row(16'h0001, 24'h5, 24'h6, 24'h7, 16'hFFFF, 16'h0000));
    add_row(tick_row(16'h0400, 24'h5, 24'h6, 24'h7, 16'hFFFF, 16'h0000));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].is_cfg) write_reg(rows[i].idx, rows[i].val);
      else send_tick(rows[i].tick, rows[i].known_n, rows[i].known_color);
    end

    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 22 : (ph == 1) ? 81 : 0;
      rx_idle_pct = (ph == 0) ? 81 : (ph == 1) ? 22 : 0;
      write_reg(CFG_SPAWN_INTERVAL, (ph == 2) ? 48'h0 : 48'($urandom_range(0, 16'h3000)));
      write_reg(CFG_VELOCITY_MIN, 48'({$urandom, $urandom}));
      write_reg(CFG_VELOCITY_MAX, 48'({$urandom, $urandom}));
      write_reg(CFG_LIFE_MIN, 48'($urandom_range(1, 16'h4000)));
      write_reg(CFG_LIFE_MAX, 48'($urandom_range(1, (ph == 2) ? 16'h1000 : 16'h4000)));
      write_reg(CFG_START_COLOR, 48'($urandom));
      write_reg(CFG_END_COLOR, 48'($urandom));
      for (int k = 0; k < 140; k++) begin
        if (ph == 2 && k == 60) hold_req = 1;
        send_tick(rand_tick(), -1, '0);
      end
      write_reg(CFG_EMITTER_ENABLE, 48'h0);
      repeat (4) send_tick(rand_tick(), -1, '0);
      write_reg(CFG_EMITTER_ENABLE, 48'h1);
    end
    s_axis_tvalid <= 1'b0;

    wait (pending_particles.size() == 0);
    repeat (SETTLE_CYC) @(posedge clk_i);
    $display("covered %0d ticks and %0d register writes; %0d particle items checked",
             ticks_sent, cfg_writes, particles_seen);
    $display("largest tick emitted %0d particles; mismatches %0d", busiest_tick, mismatches);
    if (mismatches == 0 && pending_particles.size() == 0) begin
      $display("tb_particle_pool_step: clean");
    end else begin
      $display("tb_particle_pool_step: errors");
    end
    $finish;
  end

endmodule
